[hw/rtl/actuator_lag_slew_channel_assert.svh]
// Assertion macros shared by the actuator channel RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef ACTUATOR_LAG_SLEW_CHANNEL_ASSERT_SVH
`define ACTUATOR_LAG_SLEW_CHANNEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ALSC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("actuator channel check failed");

// Next-cycle implication, disabled during reset.
`define ALSC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("actuator channel check failed");

`endif

[hw/rtl/alsc_pkg.sv]
// Shared types and constants of the actuator lag/slew channel.
// No dependencies; imported by every module of the block.
package alsc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MUL_W      = 17;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MUL_W-1:0]    mul_op_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DZ_LEVEL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_GAIN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAC = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COEFF  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 4'd7;

  // Rounding offsets for the Q14 and Q16 products
  localparam prod_t RND_Q14 = prod_t'(8192);
  localparam prod_t RND_Q16 = prod_t'(32768);

endpackage

[hw/rtl/alsc_mul.sv]
// Shared 17x17 signed multiplier with a registered product.
// Depends on alsc_pkg for the operand and product types.
module alsc_mul
  import alsc_pkg::*;
(
  input  logic    clk,
  input  mul_op_t op_a,
  input  mul_op_t op_b,
  output prod_t   prod
);

  // Register the product; the sequencer consumes it in its next step
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

[hw/rtl/actuator_lag_slew_channel.sv]
// Top level of the actuator lag/slew channel: dead zone, delay store,
// interpolation, first-order lag, slew limit and clamp around one multiplier.
// Depends on alsc_pkg, alsc_mul and actuator_lag_slew_channel_assert.svh.
//
// Usage:
//   Command samples enter on the s_axis channel (Q1.15 in tdata), one per
//   control step. Each sample yields exactly one Q1.15 output on m_axis.
//   Registers are written through cfg_write/cfg_index/cfg_data while no
//   sample is in flight; indexes above 7 are ignored.
// Sequencing:
//   A sample is accepted in the idle cycle, then runs through seven sequencer
//   steps. The next sample is taken only once the sequencer is back in idle;
//   the pace is set by the three passes through the shared multiplier and the
//   two reads of the single-read-port delay store.
// Stall:
//   The result waits in an output register; the next sample can be accepted
//   meanwhile. If that register is still full when the next result is ready,
//   the sequencer holds in its last step until the receiver takes the data.
// Reset:
//   rst clears registers to their defaults and the pointers. No clearing pass
//   is run: a fill count marks store entries never written, which read as 0.
module actuator_lag_slew_channel
  import alsc_pkg::*;
#(
  parameter int DELAY_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_axis_tdata: [15:0] command_sample
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // m_axis_tdata: [15:0] actuator_output
  output logic [15:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "actuator_lag_slew_channel_assert.svh"

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int FW = $clog2(DELAY_DEPTH + 1);
  localparam int CW = (AW > 8) ? AW : 8;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_DZ  = 3'd1;
  localparam logic [2:0] S_WR      = 3'd2;
  localparam logic [2:0] S_MUL_IP  = 3'd3;
  localparam logic [2:0] S_ADD_IP  = 3'd4;
  localparam logic [2:0] S_MUL_LAG = 3'd5;
  localparam logic [2:0] S_ADD_LAG = 3'd6;
  localparam logic [2:0] S_SLEW    = 3'd7;

  // Configuration registers
  logic [14:0] dz_level;
  logic [15:0] dz_gain;
  logic [7:0]  delay_whole;
  logic [15:0] delay_fraction;
  logic [15:0] lag_coeff;
  logic [14:0] slew_step;
  sample_t     out_min;
  sample_t     out_max;

  // Sequencer and channel state
  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] wp;
  logic [FW-1:0] fill;
  sample_t       lag_value;
  sample_t       held_output;
  sample_t       cmd_r;
  sample_t       a_r;
  sample_t       b_r;
  sample_t       d_r;
  logic          rd_valid;
  logic [15:0]   rd_data;

  // Delay store
  logic [15:0] store [DELAY_DEPTH];

  logic          accept;
  logic          out_load;
  logic [AW-1:0] n_back;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] n_ext;
  mul_op_t       op_a;
  mul_op_t       op_b;
  prod_t         prod;
  prod_t         dz_round;
  prod_t         q16_round;
  logic [17:0]   q16_sum;
  sample_t       u_val;
  sample_t       q16_base;
  logic signed [16:0] slew_diff;
  logic signed [16:0] slew_m;
  logic signed [16:0] y_val;
  sample_t       lo_bound;
  sample_t       res_val;

  // Step back a number of entries from the write pointer, modulo the depth
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] ptr,
                                              input logic [AW:0]   back);
    logic [AW:0] diff;
    begin
      diff = {1'b0, ptr} - back;
      if (diff[AW]) begin
        diff = diff + (AW+1)'(DELAY_DEPTH);
      end
      back_addr = diff[AW-1:0];
    end
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_SLEW) && (!m_axis_tvalid || m_axis_tready);

  // Saturate the whole delay to depth minus two
  assign n_ext  = (CW'(delay_whole) > CW'(DELAY_DEPTH - 2)) ? CW'(DELAY_DEPTH - 2)
                                                            : CW'(delay_whole);
  assign n_back = n_ext[AW-1:0];
  assign addr_a = back_addr(wp, {1'b0, n_back});
  assign addr_b = back_addr(wp, {1'b0, n_back} + (AW+1)'(1));
  assign rd_addr = (state == S_IDLE) ? addr_b : addr_a;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_level       <= '0;
      dz_gain        <= 16'd32768;
      delay_whole    <= '0;
      delay_fraction <= '0;
      lag_coeff      <= '0;
      slew_step      <= '0;
      out_min        <= '0;
      out_max        <= 16'sd32767;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DZ_LEVEL:    dz_level       <= cfg_data[14:0];
        REG_DZ_GAIN:     dz_gain        <= cfg_data;
        REG_DELAY_WHOLE: delay_whole    <= cfg_data[7:0];
        REG_DELAY_FRAC:  delay_fraction <= cfg_data;
        REG_LAG_COEFF:   lag_coeff      <= cfg_data;
        REG_SLEW_STEP:   slew_step      <= cfg_data[14:0];
        REG_OUT_MIN:     out_min        <= sample_t'(cfg_data);
        REG_OUT_MAX:     out_max        <= sample_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Select multiplier operands per step
  always_comb begin
    case (state)
      S_MUL_DZ: begin
        op_a = mul_op_t'(cmd_r) - mul_op_t'({2'b00, dz_level});
        op_b = mul_op_t'({1'b0, dz_gain});
      end
      S_MUL_IP: begin
        op_a = mul_op_t'(b_r) - mul_op_t'(a_r);
        op_b = mul_op_t'({1'b0, delay_fraction});
      end
      default: begin
        op_a = mul_op_t'(lag_value) - mul_op_t'(d_r);
        op_b = mul_op_t'({1'b0, lag_coeff});
      end
    endcase
  end

  alsc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Dead zone: bypassed at level 0; else rescale above the level, zero at or below
  assign dz_round = (prod + RND_Q14) >>> 14;
  always_comb begin
    if (dz_level == '0) begin
      u_val = cmd_r;
    end else if (cmd_r > sample_t'({1'b0, dz_level})) begin
      u_val = (dz_round > prod_t'(32767)) ? 16'sd32767 : sample_t'(dz_round[15:0]);
    end else begin
      u_val = '0;
    end
  end

  // Round a Q16 product and add it to its base (interpolation or lag)
  assign q16_base  = (state == S_ADD_IP) ? a_r : d_r;
  assign q16_round = (prod + RND_Q16) >>> 16;
  assign q16_sum   = {{2{q16_base[15]}}, q16_base} + q16_round[17:0];

  // Slew limit toward the lag value, then clamp
  assign slew_m    = 17'({2'b00, slew_step});
  assign slew_diff = 17'(lag_value) - 17'(held_output);
  always_comb begin
    y_val = 17'(lag_value);
    if (slew_step != '0) begin
      if (slew_diff > slew_m) begin
        y_val = 17'(held_output) + slew_m;
      end else if (slew_diff < -slew_m) begin
        y_val = 17'(held_output) - slew_m;
      end
    end
  end
  assign lo_bound = (out_min > 16'sd0) ? out_min : 16'sd0;
  always_comb begin
    if (y_val < 17'(lo_bound)) begin
      res_val = lo_bound;
    end else if (y_val > 17'(out_max)) begin
      res_val = out_max;
    end else begin
      res_val = y_val[15:0];
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept) state_next = S_MUL_DZ;
      S_MUL_DZ:  state_next = S_WR;
      S_WR:      state_next = S_MUL_IP;
      S_MUL_IP:  state_next = S_ADD_IP;
      S_ADD_IP:  state_next = S_MUL_LAG;
      S_MUL_LAG: state_next = S_ADD_LAG;
      S_ADD_LAG: state_next = S_SLEW;
      S_SLEW:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store write and registered read; flag entries not yet written
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      store[wp] <= u_val;
    end
    rd_data  <= store[rd_addr];
    rd_valid <= (FW'(rd_addr) < fill);
  end

  // Pointer, fill count and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      fill        <= '0;
      lag_value   <= '0;
      held_output <= '0;
    end else begin
      if (state == S_WR) begin
        wp <= (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + AW'(1);
        if (fill != FW'(DELAY_DEPTH)) begin
          fill <= fill + FW'(1);
        end
      end
      if (state == S_ADD_LAG) begin
        lag_value <= q16_sum[15:0];
      end
      if (out_load) begin
        held_output <= res_val;
      end
    end
  end

  // Capture command, delayed taps and interpolated sample
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= s_axis_tdata;
    end
    if (state == S_MUL_DZ) begin
      b_r <= rd_valid ? rd_data : '0;
    end
    if (state == S_WR) begin
      if (n_back == '0) begin
        a_r <= u_val;
      end else begin
        a_r <= rd_valid ? rd_data : '0;
      end
    end
    if (state == S_ADD_IP) begin
      d_r <= q16_sum[15:0];
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_val;
    end
  end

  `ALSC_ASSERT_NOW(a_fill_tracks_wp, clk, rst, fill < FW'(DELAY_DEPTH), wp == fill[AW-1:0])
  `ALSC_ASSERT_NEXT(a_wp_advance, clk, rst, state == S_WR, wp == (($past(wp) == AW'(DELAY_DEPTH - 1)) ? AW'(0) : $past(wp) + AW'(1)))
  `ALSC_ASSERT_NEXT(a_out_clamped, clk, rst, out_load, ($signed(m_axis_tdata) >= $past(lo_bound)) || ($signed(m_axis_tdata) == $past(out_max)))
  `ALSC_ASSERT_NEXT(a_held_matches_out, clk, rst, out_load, held_output == $signed(m_axis_tdata))

endmodule

[tb/actuator_lag_slew_channel_chk.sv]
// Output checker for the actuator lag/slew channel: predicts each output from the
// accepted commands and register writes, then compares the m_axis transfers in order.
// Depends on alsc_pkg for the sample type and the register indexes.
module actuator_lag_slew_channel_chk
  import alsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           cmd_tdata,
  input  logic                  cmd_tvalid,
  input  logic                  cmd_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 256;

  // Register copies
  int dz_level, dz_gain, dly_whole, dly_frac, lag_a, slew_max, clamp_lo, clamp_hi;

  // Channel state
  sample_t    hist [HIST_DEPTH];
  logic [7:0] wr_ptr;
  int         lag_q, held_q;

  sample_t expected_outputs [$];
  sample_t want;

  initial begin
    mismatches = 0;
    outstanding = 0;
    compared = 0;
  end

  function automatic int clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void restore_defaults();
    dz_level = 0;
    dz_gain = 32768;
    dly_whole = 0;
    dly_frac = 0;
    lag_a = 0;
    slew_max = 0;
    clamp_lo = 0;
    clamp_hi = 32767;
    foreach (hist[i]) hist[i] = '0;
    wr_ptr = '0;
    lag_q = 0;
    held_q = 0;
    expected_outputs.delete();
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_DZ_LEVEL:    dz_level = int'(value & 16'h7FFF);
      REG_DZ_GAIN:     dz_gain = int'(value);
      REG_DELAY_WHOLE: dly_whole = int'(value[7:0]);
      REG_DELAY_FRAC:  dly_frac = int'(value);
      REG_LAG_COEFF:   lag_a = int'(value);
      REG_SLEW_STEP:   slew_max = int'(value & 16'h7FFF);
      REG_OUT_MIN:     clamp_lo = int'(signed'(value));
      REG_OUT_MAX:     clamp_hi = int'(signed'(value));
      default: ;
    endcase
  endfunction

  // Dead zone, delay line, lag, slew and clamp for one command
  function automatic sample_t predict_output(input sample_t cmd);
    int         shaped, back, delayed, target, lo;
    longint     acc;
    logic [7:0] near_idx, far_idx;
    shaped = int'(cmd);
    if (dz_level != 0) begin
      if (shaped > dz_level) begin
        shaped = clip16((longint'(shaped - dz_level) * dz_gain + 8192) >>> 14);
      end else begin
        shaped = 0;
      end
    end
    hist[wr_ptr] = sample_t'(shaped);
    wr_ptr = wr_ptr + 8'd1;

    // Interpolate between the entries N and N+1 steps back; N saturates
    back = (dly_whole > HIST_DEPTH - 2) ? HIST_DEPTH - 2 : dly_whole;
    near_idx = wr_ptr - 8'd1 - 8'(back);
    far_idx = wr_ptr - 8'd2 - 8'(back);
    acc = longint'(hist[near_idx]) * (65536 - dly_frac)
        + longint'(hist[far_idx]) * dly_frac + 32768;
    delayed = clip16(acc >>> 16);

    acc = longint'(lag_a) * lag_q + longint'(65536 - lag_a) * delayed + 32768;
    lag_q = clip16(acc >>> 16);

    target = lag_q;
    if (slew_max != 0) begin
      if (lag_q - held_q > slew_max) target = held_q + slew_max;
      else if (lag_q - held_q < -slew_max) target = held_q - slew_max;
    end

    // Crossed clamps: the upper bound wins unless the target is below the lower
    lo = (clamp_lo > 0) ? clamp_lo : 0;
    if (target < lo) target = lo;
    else if (target > clamp_hi) target = clamp_hi;
    held_q = target;
    return sample_t'(target);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
    end else begin
      if (cfg_write) apply_write(cfg_index, cfg_data);
      // Queue the prediction for each accepted command
      if (cmd_tvalid === 1'b1 && cmd_tready === 1'b1) begin
        expected_outputs.insert(expected_outputs.size(),
                                predict_output(sample_t'(cmd_tdata)));
      end
      // Compare each output transfer with the oldest prediction
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (expected_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: actuator output mismatch: expected none, actual %0d",
                   $time, signed'(out_tdata));
        end else begin
          want = expected_outputs.pop_front();
          compared++;
          if (out_tdata !== want) begin
            mismatches++;
            $display("%0t: actuator output mismatch: expected %0d, actual %0d",
                     $time, want, signed'(out_tdata));
          end
        end
      end
    end
    outstanding = expected_outputs.size();
  end

endmodule

[tb/actuator_lag_slew_channel_tb.sv]
// Testbench top for the actuator lag/slew channel: clock, reset, command stimulus,
// register settings and the verdict. Depends on alsc_pkg, the channel RTL and
// actuator_lag_slew_channel_chk.
module actuator_lag_slew_channel_tb;
  import alsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [15:0] DIRECTED_A [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
                                               16'hFFFF, 16'h4000, 16'h7FFF, 16'h8000};
  localparam logic [15:0] DIRECTED_B [6] = '{16'h7FFF, 16'h0000, 16'h8000, 16'h5555,
                                               16'hAAAA, 16'h7FFE};
  localparam logic [15:0] DIRECTED_C [6] = '{16'h0001, 16'h0002, 16'h7FFF, 16'h7FFF,
                                               16'h8000, 16'h0100};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [15:0]           s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  int     burst_left = 0;
  int     samples_sent = 0;
  int     settings_used = 0;
  int     ramp_level = 0;
  int     mismatches, outstanding, compared;
  longint cycles = 0;

  actuator_lag_slew_channel DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  actuator_lag_slew_channel_chk output_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_tdata   (s_axis_tdata),
    .cmd_tvalid  (s_axis_tvalid),
    .cmd_tready  (s_axis_tready),
    .out_tdata   (m_axis_tdata),
    .out_tvalid  (m_axis_tvalid),
    .out_tready  (m_axis_tready),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver backpressure; always ready during a burst
  always @(negedge clk) begin
    if (burst_left > 0) m_axis_tready = 1'b1;
    else m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_cmd(input logic [15:0] value);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else if ($urandom_range(49) == 0) burst_left = 24;
    while (burst_left == 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata = value;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    samples_sent++;
  endtask

  // Hold off the sender until every predicted output has been taken
  task automatic drain_outputs();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [15:0] choose(input logic [15:0] low_v, high_v, mid_v);
    case ($urandom_range(3))
      0: return low_v;
      1: return high_v;
      default: return mid_v;
    endcase
  endfunction

  // Rewrite a random subset of the registers, extremes included
  task automatic randomize_settings();
    if ($urandom_range(1)) write_reg(REG_DZ_LEVEL, choose(16'h0000, 16'h7FFF,
                                     ($urandom_range(1)) ? 16'h0000 : 16'($urandom_range(4000, 1))));
    if ($urandom_range(1)) write_reg(REG_DZ_GAIN, choose(16'h0000, 16'hFFFF,
                                     16'($urandom_range(65535, 32768))));
    if ($urandom_range(1)) write_reg(REG_DELAY_WHOLE, choose(16'h0000, 16'h00FF,
                                     ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                                              : 16'($urandom_range(8))));
    if ($urandom_range(1)) write_reg(REG_DELAY_FRAC, choose(16'h0000, 16'hFFFF, 16'($urandom)));
    if ($urandom_range(1)) write_reg(REG_LAG_COEFF, choose(16'h0000, 16'hFFFF, 16'($urandom)));
    if ($urandom_range(1)) write_reg(REG_SLEW_STEP, choose(16'h0000, 16'h7FFF,
                                     ($urandom_range(1)) ? 16'h0001 : 16'($urandom_range(4000))));
    if ($urandom_range(1)) write_reg(REG_OUT_MIN, choose(16'h8000, 16'h7FFF, 16'($urandom)));
    if ($urandom_range(1)) write_reg(REG_OUT_MAX, choose(16'h8000, 16'h7FFF,
                                     ($urandom_range(1)) ? 16'h7FFF : 16'($urandom)));
    if ($urandom_range(7) == 0) begin
      write_reg(REG_OUT_MAX + 4'($urandom_range(8, 1)), 16'($urandom));
    end
    settings_used++;
  endtask

  // Mix of full-range noise, extremes, slow ramps and values near zero
  function automatic logic [15:0] next_command();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return 16'($urandom);
    if (pick == 4) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (pick < 8) begin
      ramp_level = ramp_level + int'($urandom_range(1200)) - 600;
      if (ramp_level > 32767) ramp_level = 32767;
      if (ramp_level < -32768) ramp_level = -32768;
      return 16'(ramp_level);
    end
    return 16'($urandom_range(400)) - 16'd200;
  endfunction

  initial begin
    int random_sent;
    int phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Early history: a delayed, interpolated read of entries never written
    write_reg(REG_DELAY_WHOLE, 16'd3);
    write_reg(REG_DELAY_FRAC, 16'h4000);
    write_reg(REG_OUT_MIN, 16'h8000);
    settings_used++;
    foreach (DIRECTED_A[i]) send_cmd(DIRECTED_A[i]);
    drain_outputs();

    // Saturated delay, full lag and slew, crossed clamps, ignored index
    write_reg(REG_DZ_LEVEL, 16'h7FFF);
    write_reg(REG_DZ_GAIN, 16'h0000);
    write_reg(REG_DELAY_WHOLE, 16'h00FF);
    write_reg(REG_DELAY_FRAC, 16'hFFFF);
    write_reg(REG_LAG_COEFF, 16'hFFFF);
    write_reg(REG_SLEW_STEP, 16'h7FFF);
    write_reg(REG_OUT_MIN, 16'h7FFF);
    write_reg(REG_OUT_MAX, 16'h8000);
    write_reg(REG_OUT_MAX + 4'd5, 16'h1234);
    settings_used++;
    foreach (DIRECTED_B[i]) send_cmd(DIRECTED_B[i]);
    drain_outputs();

    // Smallest dead zone with largest gain, zero delay, no lag, unit slew
    write_reg(REG_DZ_LEVEL, 16'h0001);
    write_reg(REG_DZ_GAIN, 16'hFFFF);
    write_reg(REG_DELAY_WHOLE, 16'h0000);
    write_reg(REG_DELAY_FRAC, 16'h0000);
    write_reg(REG_LAG_COEFF, 16'h0000);
    write_reg(REG_SLEW_STEP, 16'h0001);
    write_reg(REG_OUT_MIN, 16'h8000);
    write_reg(REG_OUT_MAX, 16'h7FFF);
    settings_used++;
    foreach (DIRECTED_C[i]) send_cmd(DIRECTED_C[i]);
    drain_outputs();

    // Random segments, one idle pattern per quarter of the run
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase = (random_sent * 4) / RANDOM_ITEMS;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      randomize_settings();
      repeat ($urandom_range(60, 20)) begin
        send_cmd(next_command());
        random_sent++;
      end
      drain_outputs();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Drove %0d command samples through %0d register settings under four idle patterns",
             samples_sent, settings_used);
    $display("Compared %0d actuator outputs, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
